[src/spi_eeprom_access_master_defines.svh]
// Assertion macros for the EEPROM SPI master.
`ifndef SPI_EEPROM_ACCESS_MASTER_DEFINES_SVH
`define SPI_EEPROM_ACCESS_MASTER_DEFINES_SVH

// Check a condition that must hold in the same cycle as its trigger
`define SEAM_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("seam: same-cycle check failed");

// Check a condition that must hold in the cycle after its trigger
`define SEAM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("seam: next-cycle check failed");

`endif

[src/seam_pkg.sv]
package seam_pkg;

    // Item kinds carried on the input tuser
    localparam logic [2:0] KIND_TICK      = 3'd0;
    localparam logic [2:0] KIND_READ_BYTE = 3'd1;
    localparam logic [2:0] KIND_READ_WORD = 3'd2;
    localparam logic [2:0] KIND_WRITE     = 3'd3;
    localparam logic [2:0] KIND_STATUS    = 3'd4;
    localparam logic [2:0] KIND_WREN      = 3'd5;
    localparam logic [2:0] KIND_WRDI      = 3'd6;

    // EEPROM instruction opcodes
    localparam logic [7:0] OP_WREN  = 8'h06;
    localparam logic [7:0] OP_WRDI  = 8'h04;
    localparam logic [7:0] OP_WRITE = 8'h02;
    localparam logic [7:0] OP_RDSR  = 8'h05;
    localparam logic [7:0] OP_READ  = 8'h03;

    // Beat widths
    localparam int InDataW  = 32;
    localparam int OutDataW = 24;

endpackage

[src/spi_eeprom_access_master.sv]
// Path: each input beat is held in the input register, and its result then in the result register.
// Throughput: one beat per cycle unless a held result beat stalls it; each beat advances the
// serial sequence by at most one half-bit, set by the single pass through the sequencer.
// Reset (rst_n, asynchronous, active low): sequencer idle, pins sclk low, mosi low, cs_n high,
// both stream registers empty.
`include "spi_eeprom_access_master_defines.svh"

module spi_eeprom_access_master
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [seam_pkg::InDataW-1:0]      s_tdata,  // address[15:0], write_data[23:16], miso[24]
    input  logic [2:0]                        s_tuser,  // kind[2:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [seam_pkg::OutDataW-1:0]     m_tdata   // sclk, mosi, cs_n, busy_res, done_res,
                                                        // read_data[20:5], rejected[21]
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WREN,
        ST_WRITE,
        ST_POLL,
        ST_READ1,
        ST_READ2,
        ST_STATUS,
        ST_WRDI
    } step_t;

    // Stream registers
    logic                          in_valid_reg;
    logic [2:0]                    in_kind_reg;
    logic [15:0]                   in_addr_reg;
    logic [7:0]                    in_wdata_reg;
    logic                          in_miso_reg;
    logic                          out_valid_reg;
    logic [seam_pkg::OutDataW-1:0] out_data_reg;

    // Sequencer state
    step_t       step_reg, step_next;
    logic [7:0]  shift_reg, shift_next;
    logic [3:0]  half_reg, half_next;
    logic [2:0]  byte_idx_reg, byte_idx_next;
    logic [2:0]  cmd_reg, cmd_next;
    logic [15:0] addr_reg, addr_next;
    logic [7:0]  data_reg, data_next;
    logic [15:0] word_reg, word_next;
    logic        pin_sclk_reg, pin_sclk_next;
    logic        pin_mosi_reg, pin_mosi_next;
    logic        pin_cs_reg, pin_cs_next;

    logic        out_free;
    logic        advance;
    logic        done;
    logic        rejected;
    logic [15:0] rdata;
    logic [2:0]  frame_len;
    logic        rx;
    logic [7:0]  tx_byte;
    logic [2:0]  bit_idx;
    logic [7:0]  shift_upd;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Frame shape for the running step
    always_comb
    begin
        case (step_reg)
            ST_WREN, ST_WRDI:            frame_len = 3'd1;
            ST_POLL, ST_STATUS:          frame_len = 3'd2;
            ST_WRITE, ST_READ1, ST_READ2: frame_len = 3'd4;
            default:                     frame_len = 3'd0;
        endcase
        case (step_reg)
            ST_POLL, ST_STATUS: rx = (byte_idx_reg == 3'd1);
            ST_READ1, ST_READ2: rx = (byte_idx_reg == 3'd3);
            default:            rx = 1'b0;
        endcase
        case (byte_idx_reg)
            3'd1:    tx_byte = addr_reg[15:8];
            3'd2:    tx_byte = addr_reg[7:0];
            3'd3:    tx_byte = data_reg;
            default:
            begin
                case (step_reg)
                    ST_WREN:            tx_byte = seam_pkg::OP_WREN;
                    ST_WRDI:            tx_byte = seam_pkg::OP_WRDI;
                    ST_WRITE:           tx_byte = seam_pkg::OP_WRITE;
                    ST_POLL, ST_STATUS: tx_byte = seam_pkg::OP_RDSR;
                    default:            tx_byte = seam_pkg::OP_READ;
                endcase
            end
        endcase
        bit_idx   = ~half_reg[3:1];
        shift_upd = (half_reg[0] && rx) ? {shift_reg[6:0], in_miso_reg} : shift_reg;
    end

    // Advance the sequencer by one beat
    always_comb
    begin
        step_next     = step_reg;
        shift_next    = shift_reg;
        half_next     = half_reg;
        byte_idx_next = byte_idx_reg;
        cmd_next      = cmd_reg;
        addr_next     = addr_reg;
        data_next     = data_reg;
        word_next     = word_reg;
        pin_sclk_next = pin_sclk_reg;
        pin_mosi_next = pin_mosi_reg;
        pin_cs_next   = pin_cs_reg;
        done          = 1'b0;
        rejected      = 1'b0;
        rdata         = 16'd0;

        if (in_kind_reg != seam_pkg::KIND_TICK)
        begin
            if (in_kind_reg inside {[seam_pkg::KIND_READ_BYTE:seam_pkg::KIND_WRDI]})
            begin
                if (step_reg != ST_IDLE)
                begin
                    rejected = 1'b1;
                end
                else
                begin
                    cmd_next      = in_kind_reg;
                    addr_next     = in_addr_reg;
                    data_next     = in_wdata_reg;
                    shift_next    = 8'd0;
                    half_next     = 4'd0;
                    byte_idx_next = 3'd0;
                    word_next     = 16'd0;
                    case (in_kind_reg)
                        seam_pkg::KIND_READ_BYTE,
                        seam_pkg::KIND_READ_WORD: step_next = ST_READ1;
                        seam_pkg::KIND_WRITE,
                        seam_pkg::KIND_WREN:      step_next = ST_WREN;
                        seam_pkg::KIND_STATUS:    step_next = ST_STATUS;
                        default:                  step_next = ST_WRDI;
                    endcase
                end
            end
        end
        else if (step_reg == ST_IDLE)
        begin
            pin_sclk_next = 1'b0;
            pin_mosi_next = 1'b0;
            pin_cs_next   = 1'b1;
        end
        else if (byte_idx_reg < frame_len)
        begin
            // Drive one half-bit and sample MISO on the high phase
            pin_sclk_next = half_reg[0];
            pin_mosi_next = rx ? 1'b0 : tx_byte[bit_idx];
            pin_cs_next   = 1'b0;
            shift_next    = shift_upd;
            half_next     = half_reg + 4'd1;
            if (half_reg == 4'd15)
            begin
                if (rx)
                begin
                    word_next  = (step_reg == ST_READ2) ? {word_reg[7:0], shift_upd}
                                                        : {8'd0, shift_upd};
                    shift_next = 8'd0;
                end
                byte_idx_next = byte_idx_reg + 3'd1;
            end
        end
        else
        begin
            // Release tick: end the frame, then chain or finish
            pin_sclk_next = 1'b0;
            pin_mosi_next = 1'b0;
            pin_cs_next   = 1'b1;
            half_next     = 4'd0;
            byte_idx_next = 3'd0;
            shift_next    = 8'd0;
            if (step_reg == ST_WREN && cmd_reg == seam_pkg::KIND_WRITE)
            begin
                step_next = ST_WRITE;
            end
            else if (step_reg == ST_WRITE)
            begin
                step_next = ST_POLL;
            end
            else if (step_reg == ST_POLL && word_reg[0])
            begin
                step_next = ST_POLL;
            end
            else if (step_reg == ST_READ1 && cmd_reg == seam_pkg::KIND_READ_WORD)
            begin
                addr_next = addr_reg + 16'd1;
                step_next = ST_READ2;
            end
            else
            begin
                done = 1'b1;
                if (step_reg == ST_READ1 || step_reg == ST_READ2 || step_reg == ST_STATUS)
                begin
                    rdata = word_reg;
                end
                step_next = ST_IDLE;
            end
        end
    end

    // Hold stream stages and sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            step_reg      <= ST_IDLE;
            shift_reg     <= 8'd0;
            half_reg      <= 4'd0;
            byte_idx_reg  <= 3'd0;
            cmd_reg       <= 3'd0;
            addr_reg      <= 16'd0;
            data_reg      <= 8'd0;
            word_reg      <= 16'd0;
            pin_sclk_reg  <= 1'b0;
            pin_mosi_reg  <= 1'b0;
            pin_cs_reg    <= 1'b1;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                in_valid_reg <= 1'b1;
                in_kind_reg  <= s_tuser;
                in_addr_reg  <= s_tdata[15:0];
                in_wdata_reg <= s_tdata[23:16];
                in_miso_reg  <= s_tdata[24];
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                out_data_reg  <= {2'b00, rejected, rdata, done, (step_next != ST_IDLE),
                                  pin_cs_next, pin_mosi_next, pin_sclk_next};
                step_reg      <= step_next;
                shift_reg     <= shift_next;
                half_reg      <= half_next;
                byte_idx_reg  <= byte_idx_next;
                cmd_reg       <= cmd_next;
                addr_reg      <= addr_next;
                data_reg      <= data_next;
                word_reg      <= word_next;
                pin_sclk_reg  <= pin_sclk_next;
                pin_mosi_reg  <= pin_mosi_next;
                pin_cs_reg    <= pin_cs_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // A finished command is never reported as still busy or rejected
    `SEAM_ASSERT_NOW(a_done_not_busy, out_valid_reg && out_data_reg[4],
                     !out_data_reg[3] && !out_data_reg[21])
    // The chip is deselected whenever the sequencer is idle
    `SEAM_ASSERT_NOW(a_idle_cs_high, step_reg == ST_IDLE, pin_cs_reg)
    // A held input beat stays while the result register is blocked
    `SEAM_ASSERT_NEXT(a_in_hold, in_valid_reg && !out_free, in_valid_reg)
    // Read data only appears with a completion
    `SEAM_ASSERT_NOW(a_rdata_with_done, out_valid_reg && !out_data_reg[4],
                     out_data_reg[20:5] == 16'd0)

endmodule
